// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file tsa_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define TSA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define TSA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/tsa_pkg.sv =====
// ----------------------------------------------------------------------------
// tsa_pkg
// Types and codes shared by the timed slot allocator modules.
// ----------------------------------------------------------------------------
package tsa_pkg;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;
   localparam logic [1:0] CMD_READ   = 2'd3;

   localparam logic [22:0] AGE_MAX = 23'h7F_FFFF;

   typedef struct packed {
      logic [1:0]         command;
      logic [7:0]         slot_handle;
      logic [31:0]        payload_in;
      logic signed [23:0] lifetime_in;
      logic [22:0]        start_age;
      logic [15:0]        elapsed;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [7:0]  result_handle;
      logic [31:0] payload_out;
      logic [22:0] age_out;
      logic [8:0]  live_count;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic signed [23:0] lifetime;
      logic [22:0]        age;
      logic [31:0]        payload;
   } slot_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_POP,
      ST_LOOKUP,
      ST_TICK,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_POP_READ,
      OP_ADD_STACK,
      OP_ADD_HIGH,
      OP_FAIL,
      OP_LOOKUP_READ,
      OP_REMOVE,
      OP_READ_OUT,
      OP_TICK_START,
      OP_TICK_STEP,
      OP_TICK_DONE,
      OP_LOAD_RSP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } ctrl_type;

   typedef struct packed {
      logic [1:0] command;
      logic       free_empty;
      logic       table_full;
      logic       handle_in_range;
      logic       table_empty;
      logic       tick_last;
      logic       rsp_free;
   } status_type;

endpackage

// ===== rtl/core/tsa_ram.sv =====
// ----------------------------------------------------------------------------
// tsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/tsa_datapath.sv =====
// ----------------------------------------------------------------------------
// tsa_datapath
// Slot table, free stack, counters and the result registers.
// ----------------------------------------------------------------------------
module tsa_datapath #(
   parameter int MAX_SLOTS = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  tsa_pkg::ctrl_type   ctrl,
   output tsa_pkg::status_type status,
   input  tsa_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tsa_pkg::rsp_type    rsp_data
);

   localparam int IW = $clog2(MAX_SLOTS);
   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int EW = (CW > 8) ? CW : 8;
   localparam int LW = (CW > 9) ? CW : 9;
   localparam int SW = $bits(tsa_pkg::slot_entry_type);

   tsa_pkg::req_type req_ff, req_in;
   tsa_pkg::rsp_type res_ff, res_in;
   tsa_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]    free_top_ff, free_top_in;
   logic [CW-1:0]    high_water_ff, high_water_in;
   logic [CW-1:0]    valid_total_ff, valid_total_in;
   logic [CW-1:0]    idx_ff, idx_in;

   logic          s_wr_en, s_rd_en;
   logic [IW-1:0] s_wr_addr, s_rd_addr;
   logic [SW-1:0] s_wr_data, s_rd_data;
   logic          k_wr_en, k_rd_en;
   logic [IW-1:0] k_wr_addr, k_rd_addr, k_wr_data, k_rd_data;

   tsa_pkg::slot_entry_type entry, new_entry;
   logic [EW-1:0] h_ext, slot_ext;
   logic          in_range;
   logic [CW-1:0] ft_dec, idx_inc;
   logic [23:0]   age_sum;
   logic [22:0]   aged;
   logic          tick_live, expired;
   logic          push_en, release_en;
   logic [IW-1:0] push_slot, add_slot;
   logic [LW-1:0] live_ext;

   tsa_ram #(.WIDTH(SW), .DEPTH(MAX_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data (s_wr_data),
      .rd_en   (s_rd_en),
      .rd_addr (s_rd_addr),
      .rd_data (s_rd_data)
   );

   tsa_ram #(.WIDTH(IW), .DEPTH(MAX_SLOTS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (k_wr_en),
      .wr_addr (k_wr_addr),
      .wr_data (k_wr_data),
      .rd_en   (k_rd_en),
      .rd_addr (k_rd_addr),
      .rd_data (k_rd_data)
   );

   assign entry    = tsa_pkg::slot_entry_type'(s_rd_data);
   assign h_ext    = EW'(req_ff.slot_handle);
   assign in_range = h_ext < EW'(high_water_ff);
   assign ft_dec   = free_top_ff - 1'b1;
   assign idx_inc  = idx_ff + 1'b1;
   assign live_ext = LW'(valid_total_ff);

   // Saturating age update and expiry test for the slot under the sweep.
   assign age_sum   = {1'b0, entry.age} + 24'(req_ff.elapsed);
   assign aged      = age_sum[23] ? tsa_pkg::AGE_MAX : age_sum[22:0];
   assign tick_live = entry.valid && !entry.lifetime[23];
   assign expired   = tick_live && ({1'b0, aged} >= $unsigned(entry.lifetime));

   always_comb begin
      req_in         = req_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      free_top_in    = free_top_ff;
      high_water_in  = high_water_ff;
      valid_total_in = valid_total_ff;
      idx_in         = idx_ff;
      s_wr_en        = 1'b0;
      s_wr_addr      = h_ext[IW-1:0];
      s_wr_data      = s_rd_data;
      s_rd_en        = 1'b0;
      s_rd_addr      = h_ext[IW-1:0];
      k_wr_en        = 1'b0;
      k_wr_addr      = free_top_ff[IW-1:0];
      k_wr_data      = h_ext[IW-1:0];
      k_rd_en        = 1'b0;
      k_rd_addr      = ft_dec[IW-1:0];
      push_en        = 1'b0;
      release_en     = 1'b0;
      push_slot      = h_ext[IW-1:0];
      add_slot       = k_rd_data;
      new_entry      = entry;
      slot_ext       = '0;

      case (ctrl.op)
         tsa_pkg::OP_CAPTURE: begin
            req_in = req_data;
         end
         tsa_pkg::OP_POP_READ: begin
            k_rd_en     = 1'b1;
            free_top_in = ft_dec;
         end
         tsa_pkg::OP_ADD_STACK, tsa_pkg::OP_ADD_HIGH: begin
            if (ctrl.op == tsa_pkg::OP_ADD_HIGH) begin
               add_slot      = high_water_ff[IW-1:0];
               high_water_in = high_water_ff + 1'b1;
            end
            new_entry.valid    = 1'b1;
            new_entry.lifetime = req_ff.lifetime_in;
            new_entry.age      = req_ff.start_age;
            new_entry.payload  = req_ff.payload_in;
            s_wr_en            = 1'b1;
            s_wr_addr          = add_slot;
            s_wr_data          = SW'(new_entry);
            valid_total_in     = valid_total_ff + 1'b1;
            slot_ext           = EW'(add_slot);
            res_in             = '0;
            res_in.ok          = 1'b1;
            res_in.result_handle = slot_ext[7:0];
         end
         tsa_pkg::OP_FAIL: begin
            res_in = '0;
         end
         tsa_pkg::OP_LOOKUP_READ: begin
            s_rd_en = 1'b1;
         end
         tsa_pkg::OP_REMOVE: begin
            res_in = '0;
            if (entry.valid) begin
               new_entry.valid = 1'b0;
               s_wr_en         = 1'b1;
               s_wr_data       = SW'(new_entry);
               push_en         = 1'b1;
               release_en      = 1'b1;
               res_in.ok       = 1'b1;
            end
         end
         tsa_pkg::OP_READ_OUT: begin
            res_in = '0;
            if (entry.valid) begin
               res_in.ok          = 1'b1;
               res_in.payload_out = entry.payload;
               res_in.age_out     = entry.age;
            end
         end
         tsa_pkg::OP_TICK_START: begin
            idx_in    = '0;
            s_rd_en   = 1'b1;
            s_rd_addr = '0;
         end
         tsa_pkg::OP_TICK_STEP: begin
            // Write back this slot while the next one is being read.
            if (tick_live) begin
               new_entry.age   = aged;
               new_entry.valid = !expired;
               s_wr_en         = 1'b1;
               s_wr_addr       = idx_ff[IW-1:0];
               s_wr_data       = SW'(new_entry);
            end
            push_en    = expired;
            release_en = expired;
            push_slot  = idx_ff[IW-1:0];
            idx_in     = idx_inc;
            s_rd_en    = 1'b1;
            s_rd_addr  = idx_inc[IW-1:0];
            res_in     = '0;
            res_in.ok  = 1'b1;
         end
         tsa_pkg::OP_TICK_DONE: begin
            res_in    = '0;
            res_in.ok = 1'b1;
         end
         tsa_pkg::OP_LOAD_RSP: begin
            rsp_in            = res_ff;
            rsp_in.live_count = live_ext[8:0];
            rsp_valid_in      = 1'b1;
         end
         default: begin
         end
      endcase

      if (push_en && (free_top_ff < CW'(MAX_SLOTS))) begin
         k_wr_en     = 1'b1;
         k_wr_data   = push_slot;
         free_top_in = free_top_ff + 1'b1;
      end
      if (release_en && (valid_total_ff != '0)) begin
         valid_total_in = valid_total_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_top_ff    <= '0;
         high_water_ff  <= '0;
         valid_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         free_top_ff    <= free_top_in;
         high_water_ff  <= high_water_in;
         valid_total_ff <= valid_total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      req_ff <= req_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
      idx_ff <= idx_in;
   end

   assign status.command         = req_ff.command;
   assign status.free_empty      = (free_top_ff == '0);
   assign status.table_full      = (high_water_ff == CW'(MAX_SLOTS));
   assign status.handle_in_range = in_range;
   assign status.table_empty     = (high_water_ff == '0);
   assign status.tick_last       = (idx_inc == high_water_ff);
   assign status.rsp_free        = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/tsa_controller.sv =====
// ----------------------------------------------------------------------------
// tsa_controller
// Sequencer that steps one command at a time through the datapath.
// ----------------------------------------------------------------------------
module tsa_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tsa_pkg::status_type status,
   output tsa_pkg::ctrl_type   ctrl
);

   tsa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tsa_pkg::ST_IDLE: begin
            if (req_valid) state_in = tsa_pkg::ST_DECODE;
         end
         tsa_pkg::ST_DECODE: begin
            case (status.command)
               tsa_pkg::CMD_ADD: begin
                  state_in = status.free_empty ? tsa_pkg::ST_FINISH : tsa_pkg::ST_POP;
               end
               tsa_pkg::CMD_REMOVE, tsa_pkg::CMD_READ: begin
                  state_in = status.handle_in_range ? tsa_pkg::ST_LOOKUP
                                                    : tsa_pkg::ST_FINISH;
               end
               default: begin
                  state_in = status.table_empty ? tsa_pkg::ST_FINISH : tsa_pkg::ST_TICK;
               end
            endcase
         end
         tsa_pkg::ST_POP, tsa_pkg::ST_LOOKUP: begin
            state_in = tsa_pkg::ST_FINISH;
         end
         tsa_pkg::ST_TICK: begin
            if (status.tick_last) state_in = tsa_pkg::ST_FINISH;
         end
         tsa_pkg::ST_FINISH: begin
            if (status.rsp_free) state_in = tsa_pkg::ST_IDLE;
         end
         default: begin
            state_in = tsa_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      ctrl.op   = tsa_pkg::OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         tsa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) ctrl.op = tsa_pkg::OP_CAPTURE;
         end
         tsa_pkg::ST_DECODE: begin
            case (status.command)
               tsa_pkg::CMD_ADD: begin
                  if (!status.free_empty) begin
                     ctrl.op = tsa_pkg::OP_POP_READ;
                  end else if (!status.table_full) begin
                     ctrl.op = tsa_pkg::OP_ADD_HIGH;
                  end else begin
                     ctrl.op = tsa_pkg::OP_FAIL;
                  end
               end
               tsa_pkg::CMD_REMOVE, tsa_pkg::CMD_READ: begin
                  ctrl.op = status.handle_in_range ? tsa_pkg::OP_LOOKUP_READ
                                                   : tsa_pkg::OP_FAIL;
               end
               default: begin
                  ctrl.op = status.table_empty ? tsa_pkg::OP_TICK_DONE
                                               : tsa_pkg::OP_TICK_START;
               end
            endcase
         end
         tsa_pkg::ST_POP: begin
            ctrl.op = tsa_pkg::OP_ADD_STACK;
         end
         tsa_pkg::ST_LOOKUP: begin
            ctrl.op = (status.command == tsa_pkg::CMD_REMOVE) ? tsa_pkg::OP_REMOVE
                                                             : tsa_pkg::OP_READ_OUT;
         end
         tsa_pkg::ST_TICK: begin
            ctrl.op = tsa_pkg::OP_TICK_STEP;
         end
         tsa_pkg::ST_FINISH: begin
            if (status.rsp_free) ctrl.op = tsa_pkg::OP_LOAD_RSP;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/core/timed_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// timed_slot_allocator
// Handle allocator over a slot table with LIFO reuse and lifetime expiry.
//
//   channel | dir | handshake            | beat
//   req     | in  | req_valid/req_ready  | tsa_pkg::req_type
//   rsp     | out | rsp_valid/rsp_ready  | tsa_pkg::rsp_type
//
// One command at a time. Add takes a slot from the free list (stack RAM
// read, then slot write) or from the high-water mark; remove and read do
// a slot RAM read, then a check; tick sweeps the slots below the mark one
// slot a cycle through the slot RAM; then the response register is loaded.
// Reset clears counters, not RAMs; the high-water mark bounds valid entries.
// A stalled response holds the block in its finish state.
// ----------------------------------------------------------------------------
module timed_slot_allocator #(
   parameter int MAX_SLOTS = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tsa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tsa_pkg::rsp_type rsp_data
);

   tsa_pkg::ctrl_type   ctrl;
   tsa_pkg::status_type status;

   tsa_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   tsa_datapath #(.MAX_SLOTS(MAX_SLOTS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/tsa_checker.sv =====
// ----------------------------------------------------------------------------
// tsa_checker
// Port-level checks for the timed slot allocator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsa_checker #(
   parameter int MAX_SLOTS = 256
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tsa_pkg::rsp_type rsp_data
);

   logic rsp_hold;
   logic req_beat;
   logic rsp_fail;
   logic fail_clean;
   logic live_in_bound;

   assign rsp_hold      = rsp_valid && !rsp_ready;
   assign req_beat      = req_valid && req_ready;
   assign rsp_fail      = rsp_valid && !rsp_data.ok;
   assign fail_clean    = (rsp_data.result_handle == 8'd0) &&
                          (rsp_data.payload_out == 32'd0) &&
                          (rsp_data.age_out == 23'd0);
   assign live_in_bound = (MAX_SLOTS > 511) || (int'(rsp_data.live_count) <= MAX_SLOTS);

   `TSA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_hold, rsp_valid && $stable(rsp_data), "rsp changed")

   `TSA_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_beat, !req_ready, "req taken while busy")

   `TSA_ASSERT_IMPL(a_fail_zero, clock, reset, rsp_fail, fail_clean, "failed rsp carries data")

   `TSA_ASSERT(a_live_bound, clock, reset, !rsp_valid || live_in_bound, "live count too high")

endmodule

bind timed_slot_allocator tsa_checker #(.MAX_SLOTS(MAX_SLOTS)) u_tsa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
